@@ rtl/ces_pkg.sv @@
// Shared types and codes for the categorized event stack.
// No dependencies; imported by every module of the block.
package ces_pkg;

    localparam int NUM_CAT = 3;
    localparam int CAT_W   = 3;
    localparam int FIELD_W = 32;

    // request function codes
    localparam logic [1:0] FN_PUSH  = 2'd0;
    localparam logic [1:0] FN_MREAD = 2'd1;
    localparam logic [1:0] FN_FREAD = 2'd2;
    localparam logic [1:0] FN_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // per-stack shift control
    typedef struct packed {
        logic push;
        logic pop;
        logic clr;
    } t_stk_ctl;

endpackage

@@ rtl/ces_cell.sv @@
// One stack entry: shifts down on push, up on pop.
// Depends on ces_pkg for the shift control struct.
module ces_cell import ces_pkg::*; #(
    parameter int W = 35
) (
    input  logic         i_clk,
    input  t_stk_ctl     i_ctl,
    input  logic [W-1:0] i_above,
    input  logic [W-1:0] i_below,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_q;
    logic [W-1:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.push) begin
            n_q = i_above;
        end else if (i_ctl.pop) begin
            n_q = i_below;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

@@ rtl/ces_stack.sv @@
// LIFO built as a row of ces_cell entries plus an occupancy counter.
// Depends on ces_pkg and ces_cell. Top of stack is cell 0.
module ces_stack import ces_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int W     = 35,
    parameter int CW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stk_ctl      i_ctl,
    input  logic [W-1:0]  i_din,
    output logic [W-1:0]  o_top,
    output logic [CW-1:0] o_count
);

    logic [W-1:0]  w_q [DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [W-1:0] w_above;
            logic [W-1:0] w_below;
            if (g == 0) begin : g_first
                assign w_above = i_din;
            end else begin : g_mid
                assign w_above = w_q[g-1];
            end
            // bottom refills with don't-care data, never read below the count
            if (g == DEPTH - 1) begin : g_last
                assign w_below = '0;
            end else begin : g_inner
                assign w_below = w_q[g+1];
            end
            ces_cell #(.W(W)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_above (w_above),
                .i_below (w_below),
                .o_q     (w_q[g])
            );
        end
    endgenerate

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.clr) begin
            n_cnt = '0;
        end else if (i_ctl.push) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_ctl.pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_top   = w_q[0];
    assign o_count = r_cnt;

endmodule

@@ rtl/categorized_event_stack.sv @@
// Categorized event stack: one master LIFO and three category LIFOs
// (system, input, window), each a row of shifting register cells.
// The result is registered and strobed in the cycle after the request is taken.
// Throughput: one request per cycle; every stack shifts its whole row at once.
// Reset clears all stack counts; entry contents are left as they are.
// The result cannot be stalled; busy stays low.
module categorized_event_stack import ces_pkg::*; #(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_func,
    input  logic               i_remove,
    input  logic [CAT_W-1:0]   i_filter_flags,
    input  logic [FIELD_W-1:0] i_event_payload,
    input  logic [CAT_W-1:0]   i_event_categories,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [FIELD_W-1:0] o_out_payload,
    output logic [CAT_W-1:0]   o_out_categories
);

    localparam int SW = (PAYLOAD_BITS < FIELD_W) ? PAYLOAD_BITS : FIELD_W;
    localparam int EW = SW + CAT_W;
    localparam int CW = $clog2(DEPTH + 1);

    logic          w_acc;
    logic [EW-1:0] w_din;
    logic [EW-1:0] w_mtop;
    logic [CW-1:0] w_mcnt;
    logic [EW-1:0] w_ctop [NUM_CAT];
    logic [CW-1:0] w_ccnt [NUM_CAT];
    t_stk_ctl      w_mctl;
    t_stk_ctl      w_cctl [NUM_CAT];

    logic          w_mfull;
    logic          w_mempty;
    logic          w_push_ok;
    logic [1:0]    w_sel;
    logic          w_sel_any;
    logic          w_cempty;
    logic [EW-1:0] w_csel_top;

    logic               r_valid;
    logic [1:0]         r_status;
    logic [FIELD_W-1:0] r_payload;
    logic [CAT_W-1:0]   r_cats;
    logic [1:0]         n_status;
    logic [FIELD_W-1:0] n_payload;
    logic [CAT_W-1:0]   n_cats;

    assign busy  = 1'b0;
    assign w_acc = start && !busy;
    assign w_din = {i_event_categories, i_event_payload[SW-1:0]};

    assign w_mfull   = (w_mcnt >= CW'(DEPTH - 1));
    assign w_mempty  = (w_mcnt == '0);
    assign w_push_ok = w_acc && (i_func == FN_PUSH) && !w_mfull;

    // filtered read: system over input over window
    always_comb begin
        w_sel     = 2'd0;
        w_sel_any = 1'b1;
        if (i_filter_flags[0]) begin
            w_sel = 2'd0;
        end else if (i_filter_flags[1]) begin
            w_sel = 2'd1;
        end else if (i_filter_flags[2]) begin
            w_sel = 2'd2;
        end else begin
            w_sel_any = 1'b0;
        end
    end

    assign w_cempty   = (w_ccnt[w_sel] == '0);
    assign w_csel_top = w_ctop[w_sel];

    always_comb begin
        w_mctl.push = w_push_ok;
        w_mctl.pop  = w_acc && (i_func == FN_MREAD) && i_remove && !w_mempty;
        w_mctl.clr  = w_acc && (i_func == FN_CLEAR);
    end

    ces_stack #(.DEPTH(DEPTH), .W(EW), .CW(CW)) u_master (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mctl),
        .i_din   (w_din),
        .o_top   (w_mtop),
        .o_count (w_mcnt)
    );

    genvar k;
    generate
        for (k = 0; k < NUM_CAT; k++) begin : g_cat
            // a full category stack ignores the push
            always_comb begin
                w_cctl[k].push = w_push_ok && i_event_categories[k]
                                 && (w_ccnt[k] != CW'(DEPTH));
                w_cctl[k].pop  = w_acc && (i_func == FN_FREAD) && i_remove && w_sel_any
                                 && (w_sel == 2'(k)) && !w_cempty;
                w_cctl[k].clr  = w_acc && (i_func == FN_CLEAR);
            end

            ces_stack #(.DEPTH(DEPTH), .W(EW), .CW(CW)) u_cat (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_cctl[k]),
                .i_din   (w_din),
                .o_top   (w_ctop[k]),
                .o_count (w_ccnt[k])
            );
        end
    endgenerate

    always_comb begin
        n_status  = ST_OK;
        n_payload = '0;
        n_cats    = '0;
        case (i_func)
            FN_PUSH: begin
                if (w_mfull) begin
                    n_status = ST_FULL;
                end
            end
            FN_MREAD: begin
                if (w_mempty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_payload = FIELD_W'(w_mtop[SW-1:0]);
                    n_cats    = w_mtop[EW-1:SW];
                end
            end
            FN_FREAD: begin
                if (!w_sel_any || w_cempty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_payload = FIELD_W'(w_csel_top[SW-1:0]);
                    n_cats    = w_csel_top[EW-1:SW];
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status  <= n_status;
            r_payload <= n_payload;
            r_cats    <= n_cats;
        end
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_out_payload    = r_payload;
    assign o_out_categories = r_cats;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("request taken without a result strobe");

    a_full_only_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func != FN_PUSH) |=> (o_status != ST_FULL))
        else $error("full status on a non-push request");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FN_CLEAR) |=>
        (w_mcnt == '0 && w_ccnt[0] == '0 && w_ccnt[1] == '0 && w_ccnt[2] == '0))
        else $error("stacks not empty after clear");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_out_payload == '0 && o_out_categories == '0))
        else $error("error result carries event data");

    a_master_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FN_PUSH && w_mfull) |=> $stable(w_mcnt))
        else $error("refused push changed the master count");

endmodule

@@ verif/categorized_event_stack_tb.sv @@
`timescale 1ns / 100ps
// Testbench for categorized_event_stack: random and directed push, read and clear requests,
// checked against an in-bench model of the four stacks. Depends on ces_pkg and the block RTL.
module categorized_event_stack_tb import ces_pkg::*;;

    localparam int DEPTH        = 64;
    localparam int PAYLOAD_BITS = 32;
    localparam int NUM_ITEMS    = 1550;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 100;

    typedef struct packed {
        logic [FIELD_W-1:0] payload;
        logic [CAT_W-1:0]   cats;
    } t_stack_entry;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] payload;
        logic [CAT_W-1:0]   cats;
    } t_stack_result;

    typedef struct {
        logic [1:0]         func;
        logic               remove;
        logic [CAT_W-1:0]   filt;
        logic [FIELD_W-1:0] payload;
        logic [CAT_W-1:0]   cats;
        int                 gap;
        bit                 hold;
    } t_stack_request;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_func = FN_PUSH;
    logic               i_remove = 1'b0;
    logic [CAT_W-1:0]   i_filter_flags = '0;
    logic [FIELD_W-1:0] i_event_payload = '0;
    logic [CAT_W-1:0]   i_event_categories = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [FIELD_W-1:0] o_out_payload;
    logic [CAT_W-1:0]   o_out_categories;

    // model state
    t_stack_entry master_stk [DEPTH];
    t_stack_entry cat_stk [NUM_CAT][DEPTH];
    int           master_cnt;
    int           cat_cnt [NUM_CAT];

    t_stack_request request_q[$];
    t_stack_result  pending_results[$];
    t_stack_request drv_req;
    t_stack_request taken_req;
    t_stack_result  want;
    bit             req_taken;
    bit             gap_loaded;
    bit             gaps_on;
    int             gap_left;
    int             stall_cycles;
    int             mismatches;

    categorized_event_stack #(
        .DEPTH       (DEPTH),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_remove          (i_remove),
        .i_filter_flags    (i_filter_flags),
        .i_event_payload   (i_event_payload),
        .i_event_categories(i_event_categories),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_out_payload     (o_out_payload),
        .o_out_categories  (o_out_categories)
    );

    always #1 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got,
                     exp_val);
        mismatches++;
    endtask

    // Applies one request to the model stacks and returns the result it produces.
    task automatic apply_request(input t_stack_request rq, output t_stack_result res);
        int sel;
        int c;
        res = '0;
        res.status = ST_OK;
        case (rq.func)
            FN_PUSH: begin
                if (master_cnt >= DEPTH - 1) begin
                    res.status = ST_FULL;
                end else begin
                    master_stk[master_cnt] = '{payload: rq.payload, cats: rq.cats};
                    master_cnt++;
                    for (c = 0; c < NUM_CAT; c++) begin
                        // a full category stack drops the push silently
                        if (rq.cats[c] && cat_cnt[c] < DEPTH) begin
                            cat_stk[c][cat_cnt[c]] = '{payload: rq.payload, cats: rq.cats};
                            cat_cnt[c]++;
                        end
                    end
                end
            end
            FN_MREAD: begin
                if (master_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.payload = master_stk[master_cnt-1].payload;
                    res.cats    = master_stk[master_cnt-1].cats;
                    if (rq.remove)
                        master_cnt--;
                end
            end
            FN_FREAD: begin
                // priority: system, then input, then window
                if (rq.filt[0])
                    sel = 0;
                else if (rq.filt[1])
                    sel = 1;
                else if (rq.filt[2])
                    sel = 2;
                else
                    sel = -1;
                if (sel < 0 || cat_cnt[sel] == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.payload = cat_stk[sel][cat_cnt[sel]-1].payload;
                    res.cats    = cat_stk[sel][cat_cnt[sel]-1].cats;
                    if (rq.remove)
                        cat_cnt[sel]--;
                end
            end
            default: begin
                master_cnt = 0;
                for (c = 0; c < NUM_CAT; c++)
                    cat_cnt[c] = 0;
            end
        endcase
    endtask

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_req(input logic [1:0] func, input logic remove,
                           input logic [CAT_W-1:0] filt, input logic [FIELD_W-1:0] payload,
                           input logic [CAT_W-1:0] cats, input bit hold);
        t_stack_request rq;
        rq.func    = func;
        rq.remove  = remove;
        rq.filt    = filt;
        rq.payload = payload;
        rq.cats    = cats;
        rq.gap     = rand_gap();
        rq.hold    = hold;
        request_q.push_back(rq);
    endtask

    // Fill the master stack past full, drain it, then overfill and drain the category stacks.
    task automatic add_fill_burst();
        int i;
        add_req(FN_CLEAR, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
                3'($urandom_range(0, 7)), 1'b1);
        for (i = 0; i < DEPTH + 3; i++)
            add_req(FN_PUSH, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
                    ($urandom_range(0, 3) != 0) ? 3'd7 : 3'($urandom_range(0, 7)), 1'b0);
        for (i = 0; i < DEPTH + 2; i++)
            add_req(FN_MREAD, $urandom_range(0, 7) != 0, 3'($urandom_range(0, 7)), $urandom,
                    3'($urandom_range(0, 7)), 1'b0);
        for (i = 0; i < 10; i++)
            add_req(FN_PUSH, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
                    3'd7, 1'b0);
        for (i = 0; i < DEPTH + 8; i++)
            add_req(FN_FREAD, $urandom_range(0, 7) != 0, 3'($urandom_range(1, 7)), $urandom,
                    3'($urandom_range(0, 7)), 1'b0);
    endtask

    task automatic add_random_mix(input int n);
        int i;
        int r;
        logic [1:0] func;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 42)
                func = FN_PUSH;
            else if (r < 67)
                func = FN_MREAD;
            else if (r < 97)
                func = FN_FREAD;
            else
                func = FN_CLEAR;
            add_req(func, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom,
                    3'($urandom_range(0, 7)), $urandom_range(0, 99) == 0);
        end
    endtask

    // driver: next request goes out at the falling edge once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            req_taken = 1'b0;
            if (request_q.size() == 0) begin
                start <= 1'b0;
            end else begin
                if (!gap_loaded) begin
                    gap_left   = request_q[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (request_q[0].hold && pending_results.size() != 0) begin
                    start <= 1'b0;
                end else begin
                    drv_req = request_q.pop_front();
                    gap_loaded = 1'b0;
                    i_func             <= drv_req.func;
                    i_remove           <= drv_req.remove;
                    i_filter_flags     <= drv_req.filt;
                    i_event_payload    <= drv_req.payload;
                    i_event_categories <= drv_req.cats;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_cycles++;
            if (o_valid) begin
                stall_cycles = 0;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result status", 32'(o_status), 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", 32'(o_status), 32'(want.status));
                    if (o_out_payload !== want.payload)
                        report_mismatch("payload", o_out_payload, want.payload);
                    if (o_out_categories !== want.cats)
                        report_mismatch("categories", 32'(o_out_categories),
                                        32'(want.cats));
                end
            end
            if (start && !busy) begin
                stall_cycles = 0;
                taken_req.func    = i_func;
                taken_req.remove  = i_remove;
                taken_req.filt    = i_filter_flags;
                taken_req.payload = i_event_payload;
                taken_req.cats    = i_event_categories;
                apply_request(taken_req, want);
                pending_results.push_back(want);
                req_taken = 1'b1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        master_cnt   = 0;
        cat_cnt      = '{default: 0};
        mismatches   = 0;
        stall_cycles = 0;
        req_taken    = 1'b0;
        gap_loaded   = 1'b0;
        gap_left     = 0;
        gaps_on      = 1'b1;

        // directed: empty reads, field extremes, every operation and filter priority
        add_req(FN_MREAD, 1'b1, 3'd0, '0, 3'd0, 1'b0);
        add_req(FN_FREAD, 1'b1, 3'd0, '0, 3'd0, 1'b0);
        add_req(FN_FREAD, 1'b0, 3'd1, '1, 3'd7, 1'b0);
        add_req(FN_PUSH, 1'b0, 3'd7, 32'h0000_0000, 3'd0, 1'b0);
        add_req(FN_PUSH, 1'b1, 3'd0, 32'hFFFF_FFFF, 3'd7, 1'b0);
        add_req(FN_PUSH, 1'b0, 3'd0, 32'hA5A5_5A5A, 3'd1, 1'b0);
        add_req(FN_PUSH, 1'b1, 3'd7, 32'h5A5A_A5A5, 3'd2, 1'b0);
        add_req(FN_PUSH, 1'b0, 3'd0, 32'h1234_5678, 3'd4, 1'b0);
        add_req(FN_FREAD, 1'b0, 3'd7, '1, 3'd7, 1'b0);
        add_req(FN_FREAD, 1'b1, 3'd6, '0, 3'd0, 1'b0);
        add_req(FN_FREAD, 1'b1, 3'd4, '0, 3'd0, 1'b0);
        add_req(FN_FREAD, 1'b0, 3'd2, '0, 3'd0, 1'b0);
        add_req(FN_FREAD, 1'b1, 3'd0, '0, 3'd0, 1'b0);
        add_req(FN_MREAD, 1'b0, 3'd7, '1, 3'd7, 1'b0);
        add_req(FN_MREAD, 1'b1, 3'd0, '0, 3'd0, 1'b0);
        add_req(FN_MREAD, 1'b1, 3'd0, '0, 3'd0, 1'b0);
        add_req(FN_FREAD, 1'b1, 3'd1, '0, 3'd0, 1'b0);
        add_req(FN_CLEAR, 1'b1, 3'd7, '1, 3'd7, 1'b1);
        add_req(FN_MREAD, 1'b0, 3'd0, '0, 3'd0, 1'b0);
        add_req(FN_FREAD, 1'b0, 3'd7, '0, 3'd0, 1'b0);

        add_fill_burst();
        gaps_on = 1'b0;
        add_fill_burst();
        while (request_q.size() < NUM_ITEMS) begin
            gaps_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) == 0)
                add_fill_burst();
            else
                add_random_mix($urandom_range(20, 120));
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (request_q.size() != 0 || start || pending_results.size() != 0);
        repeat (4) @(negedge i_clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
